/* src/vfhp_pkg.sv */
// vfhp_pkg: shared types and constants of the video frame header parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package vfhp_pkg;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HEAD = 2'd1,
        PH_EXT  = 2'd2,
        PH_LEN  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_I     = 2'd0,
        KIND_P     = 2'd1,
        KIND_AUDIO = 2'd2
    } t_kind;

    localparam logic [31:0] START_I     = 32'h0000_01ED;
    localparam logic [31:0] START_P     = 32'h0000_01EC;
    localparam logic [31:0] START_AUDIO = 32'h0000_01EA;
    localparam logic [7:0]  CODE_I      = 8'hED;
    localparam logic [7:0]  CODE_P      = 8'hEC;

    localparam int unsigned CNT_W      = 17;
    localparam int unsigned HDR_BYTES  = 16;
    localparam logic [16:0] HUNT_FULL  = 17'd4;
    localparam logic [16:0] HDR_LAST   = 17'd15;
    localparam logic [16:0] EXT_LEN_LO = 17'd2;
    localparam logic [16:0] EXT_LEN_HI = 17'd3;
    localparam logic [16:0] EXT_PREFIX = 17'd4;
    localparam logic [23:0] BASE_HDR   = 24'd20;
    localparam logic [7:0]  SEQ_TOP    = 8'd255;
    localparam logic [7:0]  STEREO_MIN = 8'd2;

    // fixed header bytes 0..11 as seen by the descriptor builder
    typedef struct packed {
        t_kind            kind;
        logic [11:0][7:0] hdr;
        logic [31:0]      len;
        logic [23:0]      ext_total;
        logic [7:0]       prev_seq;
    } t_snap;

    typedef struct packed {
        t_kind       frame_kind;
        logic [7:0]  codec;
        logic [4:0]  frame_rate;
        logic [15:0] width;
        logic [15:0] height;
        logic        audio_stereo;
        logic [7:0]  audio_rate_code;
        logic        audio_wide_samples;
        logic [16:0] time_of_day;
        logic [14:0] date_code;
        logic [31:0] frame_length;
        logic [23:0] header_length;
    } t_desc;

    function automatic logic [7:0] map_codec(input logic [7:0] b);
        logic [7:0] c;
        case (b)
            8'd1:    c = 8'd0;
            8'd2:    c = 8'd1;
            8'd3:    c = 8'd2;
            8'd4:    c = 8'd3;
            8'd5:    c = 8'd4;
            default: c = 8'd1;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/vfhp_in_stage.sv */
// vfhp_in_stage: input register for the byte stream, doubles as skid stage
// uses vfhp_pkg for the counter width only
`timescale 1ns / 1ps
`default_nettype none

module vfhp_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte_value,
    output logic            o_stall,
    input  wire logic       i_adv,
    output logic            o_valid,
    output logic [7:0]      o_byte
);
    import vfhp_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_stall = r_valid && !i_adv;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_byte <= i_byte_value;
        end
    end

    // held item is never dropped while the next stage stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_adv) |=> (r_valid && $stable(r_byte)))
        else $error("held item lost");

    a_width: assert property (@(posedge i_clk) CNT_W == 17)
        else $error("counter width");

endmodule

`default_nettype wire

/* src/vfhp_desc.sv */
// vfhp_desc: builds the descriptor from the collected header, with the P sequence check
// uses vfhp_pkg types t_snap, t_desc and the codec mapping
`timescale 1ns / 1ps
`default_nettype none

module vfhp_desc (
    input  wire vfhp_pkg::t_snap i_snap,
    output vfhp_pkg::t_desc o_desc,
    output logic [7:0]      o_next_seq
);
    import vfhp_pkg::*;

    logic [7:0]  seq;
    logic [7:0]  prev_eff;
    logic        jump;
    logic [31:0] dt;
    logic        is_audio;

    assign seq      = i_snap.hdr[3];
    assign prev_eff = (i_snap.prev_seq == 8'd0) ? seq : i_snap.prev_seq;
    assign jump     = ((9'(seq) > (9'(prev_eff) + 9'd1)) || (seq < prev_eff))
                      && !((seq == 8'd0) && (prev_eff == SEQ_TOP));
    assign dt       = {i_snap.hdr[11], i_snap.hdr[10], i_snap.hdr[9], i_snap.hdr[8]};
    assign is_audio = (i_snap.kind == KIND_AUDIO);

    assign o_next_seq = is_audio ? i_snap.prev_seq : seq;

    always_comb begin
        o_desc.frame_kind         = i_snap.kind;
        o_desc.codec              = is_audio ? i_snap.hdr[4] : map_codec(i_snap.hdr[0]);
        o_desc.frame_rate         = i_snap.hdr[2][4:0];
        o_desc.width              = {i_snap.hdr[5], i_snap.hdr[4]};
        o_desc.height             = {i_snap.hdr[7], i_snap.hdr[6]};
        o_desc.audio_stereo       = is_audio && (i_snap.hdr[5] >= STEREO_MIN);
        o_desc.audio_rate_code    = is_audio ? i_snap.hdr[6] : 8'd0;
        o_desc.audio_wide_samples = is_audio && (i_snap.hdr[7] != 8'd0);
        o_desc.time_of_day        = dt[16:0];
        o_desc.date_code          = dt[31:17];
        o_desc.frame_length       = ((i_snap.kind == KIND_P) && jump) ?
                                    (i_snap.len - 32'd1) : i_snap.len;
        o_desc.header_length      = BASE_HDR + i_snap.ext_total;
    end

    // byte 1 carries nothing the descriptor reports
    logic unused_hdr;
    assign unused_hdr = ^i_snap.hdr[1];

endmodule

`default_nettype wire

/* src/vfhp_parser.sv */
// vfhp_parser: start code hunt, header and extension collection, length word assembly
// uses vfhp_pkg and instantiates vfhp_desc
`timescale 1ns / 1ps
`default_nettype none

module vfhp_parser (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_go,
    input  wire logic [7:0] i_byte,
    output logic            o_emit,
    output vfhp_pkg::t_desc o_desc
);
    import vfhp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [31:0] r_window, n_window;
    logic [16:0] r_cnt, n_cnt;
    logic [7:0]  r_ext_left, n_ext_left;
    logic [23:0] r_ext_total, n_ext_total;
    logic [31:0] r_len, n_len;
    logic [7:0]  r_prev_seq, n_prev_seq;
    logic [7:0]  r_hb [HDR_BYTES];

    logic [31:0] win_next;
    logic [16:0] hunt_cnt;
    logic        hunt_match;
    logic        head_last;
    logic [16:0] ext_span;
    logic        ext_done;
    logic [7:0]  ext_left_dec;
    logic [31:0] len_or;
    logic        len_last;
    t_snap       snap;
    logic [7:0]  next_seq;

    assign win_next   = {r_window[23:0], i_byte};
    assign hunt_cnt   = (r_cnt < HUNT_FULL) ? (r_cnt + 17'd1) : r_cnt;
    assign hunt_match = (hunt_cnt >= HUNT_FULL) &&
                        ((win_next == START_I) || (win_next == START_P) ||
                         (win_next == START_AUDIO));
    assign head_last  = (r_cnt == HDR_LAST);
    assign ext_span   = (r_cnt == EXT_LEN_HI) ? (17'({i_byte, r_len[7:0]}) + EXT_PREFIX)
                                              : r_len[16:0];
    assign ext_done   = (r_cnt >= EXT_LEN_HI) && ((18'(r_cnt) + 18'd1) >= 18'(ext_span));
    assign ext_left_dec = r_ext_left - 8'd1;
    assign len_or     = r_len | (32'(i_byte) << {r_cnt[1:0], 3'b000});
    assign len_last   = (r_cnt[1:0] == 2'd3);

    always_comb begin
        n_phase = r_phase;
        if (i_go) begin
            unique case (r_phase)
                PH_HUNT: if (hunt_match) n_phase = PH_HEAD;
                PH_HEAD: begin
                    if (head_last) n_phase = (r_hb[14] != 8'd0) ? PH_EXT : PH_LEN;
                end
                PH_EXT: if (ext_done && (ext_left_dec == 8'd0)) n_phase = PH_LEN;
                PH_LEN: if (len_last) n_phase = PH_HUNT;
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    always_comb begin
        n_window    = r_window;
        n_cnt       = r_cnt;
        n_ext_left  = r_ext_left;
        n_ext_total = r_ext_total;
        n_len       = r_len;
        n_prev_seq  = r_prev_seq;
        o_emit      = 1'b0;
        if (i_go) begin
            unique case (r_phase)
                PH_HUNT: begin
                    n_window = win_next;
                    n_cnt    = hunt_match ? 17'd0 : hunt_cnt;
                end
                PH_HEAD: begin
                    if (head_last) begin
                        n_ext_left  = r_hb[14];
                        n_ext_total = 24'd0;
                        n_len       = 32'd0;
                        n_cnt       = 17'd0;
                    end else begin
                        n_cnt = r_cnt + 17'd1;
                    end
                end
                PH_EXT: begin
                    if (r_cnt == EXT_LEN_LO) begin
                        n_len = 32'(i_byte);
                    end else if (r_cnt == EXT_LEN_HI) begin
                        n_len       = 32'(ext_span);
                        n_ext_total = r_ext_total + 24'(ext_span);
                    end
                    if (ext_done) begin
                        n_cnt      = 17'd0;
                        n_ext_left = ext_left_dec;
                        if (ext_left_dec == 8'd0) n_len = 32'd0;
                    end else begin
                        n_cnt = r_cnt + 17'd1;
                    end
                end
                PH_LEN: begin
                    n_len = len_or;
                    if (len_last) begin
                        o_emit     = 1'b1;
                        n_cnt      = 17'd0;
                        n_prev_seq = next_seq;
                    end else begin
                        n_cnt = r_cnt + 17'd1;
                    end
                end
                default: n_cnt = r_cnt;
            endcase
        end
    end

    always_comb begin
        snap.kind = (r_window[7:0] == CODE_I) ? KIND_I :
                    (r_window[7:0] == CODE_P) ? KIND_P : KIND_AUDIO;
        for (int k = 0; k < 12; k++) snap.hdr[k] = r_hb[k];
        snap.len       = len_or;
        snap.ext_total = r_ext_total;
        snap.prev_seq  = r_prev_seq;
    end

    vfhp_desc u_desc (
        .i_snap     (snap),
        .o_desc     (o_desc),
        .o_next_seq (next_seq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_window    <= 32'd0;
            r_cnt       <= 17'd0;
            r_ext_left  <= 8'd0;
            r_ext_total <= 24'd0;
            r_len       <= 32'd0;
            r_prev_seq  <= 8'd0;
        end else begin
            r_phase     <= n_phase;
            r_window    <= n_window;
            r_cnt       <= n_cnt;
            r_ext_left  <= n_ext_left;
            r_ext_total <= n_ext_total;
            r_len       <= n_len;
            r_prev_seq  <= n_prev_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && (r_phase == PH_HEAD)) begin
            r_hb[r_cnt[3:0]] <= i_byte;
        end
    end

    a_hunt_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HUNT) |-> (r_cnt <= HUNT_FULL))
        else $error("hunt count beyond window");

    a_head_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEAD) |-> (r_cnt <= HDR_LAST))
        else $error("header position out of range");

    a_ext_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EXT) |-> (r_ext_left != 8'd0))
        else $error("extension phase with none left");

    a_len_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LEN) |-> (r_cnt <= EXT_LEN_HI))
        else $error("length position out of range");

    a_emit_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> (r_phase == PH_HUNT) && (r_cnt == 17'd0))
        else $error("no return to hunt after item");

endmodule

`default_nettype wire

/* src/video_frame_header_parser.sv */
// channel   | valid    | stall    | payload
// bytes in  | i_valid  | o_stall  | i_byte_value
// frames out| o_valid  | i_stall  | o_frame_kind .. o_header_length
//
// one byte per clock sustained while o_stall stays low
// byte path: input register, parser logic, descriptor register
// i_rst_n is synchronous; control and parser state clear, header store does not
// the input register acts as skid stage so o_stall only rises while a descriptor waits
// depends on vfhp_pkg, vfhp_in_stage and vfhp_parser
`timescale 1ns / 1ps
`default_nettype none

module video_frame_header_parser (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte_value,
    output logic            o_stall,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_frame_kind,
    output logic [7:0]      o_codec,
    output logic [4:0]      o_frame_rate,
    output logic [15:0]     o_width,
    output logic [15:0]     o_height,
    output logic            o_audio_stereo,
    output logic [7:0]      o_audio_rate_code,
    output logic            o_audio_wide_samples,
    output logic [16:0]     o_time_of_day,
    output logic [14:0]     o_date_code,
    output logic [31:0]     o_frame_length,
    output logic [23:0]     o_header_length
);
    import vfhp_pkg::*;

    logic       adv;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       go;
    logic       emit;
    t_desc      desc;
    logic       r_out_valid;
    t_desc      r_out;

    assign adv = !r_out_valid || !i_stall;
    assign go  = in_valid && adv;

    vfhp_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_byte_value (i_byte_value),
        .o_stall      (o_stall),
        .i_adv        (adv),
        .o_valid      (in_valid),
        .o_byte       (in_byte)
    );

    vfhp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_byte  (in_byte),
        .o_emit  (emit),
        .o_desc  (desc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_out <= desc;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_frame_kind         = r_out.frame_kind;
    assign o_codec              = r_out.codec;
    assign o_frame_rate         = r_out.frame_rate;
    assign o_width              = r_out.width;
    assign o_height             = r_out.height;
    assign o_audio_stereo       = r_out.audio_stereo;
    assign o_audio_rate_code    = r_out.audio_rate_code;
    assign o_audio_wide_samples = r_out.audio_wide_samples;
    assign o_time_of_day        = r_out.time_of_day;
    assign o_date_code          = r_out.date_code;
    assign o_frame_length       = r_out.frame_length;
    assign o_header_length      = r_out.header_length;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall))
        else $error("input stalled without a waiting item");

    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && emit) |=> r_out_valid)
        else $error("descriptor not registered");

    a_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> go)
        else $error("descriptor without a byte");

endmodule

`default_nettype wire

/* bench/video_frame_header_parser_tb.sv */
// video_frame_header_parser_tb: self-checking bench for the byte-serial frame header parser
// drives a byte stream, predicts each descriptor and compares it field by field on the output
// depends on vfhp_pkg and video_frame_header_parser
`timescale 1ns / 1ps

module video_frame_header_parser_tb;

    import vfhp_pkg::*;

    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES = 20;
    localparam int unsigned RANDOM_BYTES = 400;
    localparam int unsigned RANDOM_FRAMES = 6;

    typedef struct packed {
        logic [7:0] val;
        logic [3:0] gap;
        logic       hold;
    } t_stream_byte;

    typedef struct packed {
        t_desc       d;
        logic [31:0] stamp;
    } t_due;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_byte_value = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_frame_kind;
    logic [7:0]  o_codec;
    logic [4:0]  o_frame_rate;
    logic [15:0] o_width;
    logic [15:0] o_height;
    logic        o_audio_stereo;
    logic [7:0]  o_audio_rate_code;
    logic        o_audio_wide_samples;
    logic [16:0] o_time_of_day;
    logic [14:0] o_date_code;
    logic [31:0] o_frame_length;
    logic [23:0] o_header_length;

    // stream to send and descriptors still owed by the block
    t_stream_byte byte_q[$];
    t_due         desc_due[$];
    int unsigned  descs_made = 0;
    int unsigned  descs_done = 0;
    int unsigned  faults = 0;
    int unsigned  idle_cycles = 0;

    // generator state
    bit          gen_quiet = 1'b0;
    bit          gen_hold = 1'b0;
    logic [23:0] gen_hist = 24'hFF_FFFF;
    logic [7:0]  gen_seq = 8'd0;
    int unsigned gen_count = 0;
    int unsigned frames_made = 0;

    // driver state
    t_stream_byte tx_item;
    bit           tx_loaded;
    bit           tx_busy;
    int unsigned  tx_wait;
    logic [31:0]  drv_edge;

    // monitor state
    bit           rx_quiet;
    int unsigned  rx_wait;
    logic [31:0]  mon_edge;

    // parser shadow
    logic [31:0] hunt_window;
    t_phase      phase;
    logic [7:0]  hdr_store [16];
    logic [16:0] pos;
    logic [7:0]  ext_left;
    logic [23:0] ext_sum;
    logic [31:0] len_word;
    logic [7:0]  last_seq;

    video_frame_header_parser u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .i_byte_value         (i_byte_value),
        .o_stall              (o_stall),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_frame_kind         (o_frame_kind),
        .o_codec              (o_codec),
        .o_frame_rate         (o_frame_rate),
        .o_width              (o_width),
        .o_height             (o_height),
        .o_audio_stereo       (o_audio_stereo),
        .o_audio_rate_code    (o_audio_rate_code),
        .o_audio_wide_samples (o_audio_wide_samples),
        .o_time_of_day        (o_time_of_day),
        .o_date_code          (o_date_code),
        .o_frame_length       (o_frame_length),
        .o_header_length      (o_header_length)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [7:0] CODE_AUDIO_BYTE();
        return START_AUDIO[7:0];
    endfunction

    task automatic parse_byte(input logic [7:0] b);
        t_due        due;
        t_kind       kind;
        logic [31:0] stamp_word;
        logic [31:0] flen;
        logic [7:0]  codec;
        int unsigned seq;
        int unsigned prev;
        case (phase)
            PH_HEAD: begin
                hdr_store[pos[3:0]] = b;
                pos = pos + 17'd1;
                if (pos >= 17'd16) begin
                    ext_left = hdr_store[14];
                    ext_sum = 24'd0;
                    len_word = 32'd0;
                    pos = 17'd0;
                    phase = (ext_left != 8'd0) ? PH_EXT : PH_LEN;
                end
            end
            PH_EXT: begin
                if (pos == 17'd2) begin
                    len_word = {24'd0, b};
                end else if (pos == 17'd3) begin
                    len_word = 32'd4 + (len_word | {16'd0, b, 8'd0});
                    ext_sum = ext_sum + len_word[23:0];
                end
                if (pos >= 17'd3 && {15'd0, pos} + 32'd1 >= len_word) begin
                    pos = 17'd0;
                    ext_left = ext_left - 8'd1;
                    if (ext_left == 8'd0) begin
                        len_word = 32'd0;
                        phase = PH_LEN;
                    end
                end else begin
                    pos = pos + 17'd1;
                end
            end
            PH_LEN: begin
                len_word = len_word | ({24'd0, b} << (8 * pos[1:0]));
                if (pos[1:0] == 2'd3) begin
                    kind = (hunt_window[7:0] == CODE_I) ? KIND_I :
                           (hunt_window[7:0] == CODE_P) ? KIND_P : KIND_AUDIO;
                    stamp_word = {hdr_store[11], hdr_store[10], hdr_store[9], hdr_store[8]};
                    flen = len_word;
                    case (hdr_store[0])
                        8'd1:    codec = 8'd0;
                        8'd2:    codec = 8'd1;
                        8'd3:    codec = 8'd2;
                        8'd4:    codec = 8'd3;
                        8'd5:    codec = 8'd4;
                        default: codec = 8'd1;
                    endcase
                    due.d.audio_stereo = 1'b0;
                    due.d.audio_rate_code = 8'd0;
                    due.d.audio_wide_samples = 1'b0;
                    if (kind == KIND_I) begin
                        last_seq = hdr_store[3];
                    end else if (kind == KIND_P) begin
                        if (last_seq == 8'd0)
                            last_seq = hdr_store[3];
                        seq = hdr_store[3];
                        prev = last_seq;
                        // a step of one, a repeat or the 255 to 0 wrap is no gap
                        if ((seq > prev + 1 || seq < prev) && !(seq == 0 && prev == 255))
                            flen = flen - 32'd1;
                        last_seq = hdr_store[3];
                    end else begin
                        codec = hdr_store[4];
                        due.d.audio_stereo = (hdr_store[5] >= 8'd2);
                        due.d.audio_rate_code = hdr_store[6];
                        due.d.audio_wide_samples = (hdr_store[7] != 8'd0);
                    end
                    due.d.frame_kind = kind;
                    due.d.codec = codec;
                    due.d.frame_rate = hdr_store[2][4:0];
                    due.d.width = {hdr_store[5], hdr_store[4]};
                    due.d.height = {hdr_store[7], hdr_store[6]};
                    due.d.time_of_day = stamp_word[16:0];
                    due.d.date_code = {stamp_word[31:26], stamp_word[25:22], stamp_word[21:17]};
                    due.d.frame_length = flen;
                    due.d.header_length = 24'd20 + ext_sum;
                    due.stamp = drv_edge;
                    desc_due.push_back(due);
                    descs_made++;
                    phase = PH_HUNT;
                    pos = 17'd0;
                end else begin
                    pos = pos + 17'd1;
                end
            end
            default: begin
                phase = PH_HUNT;
                hunt_window = {hunt_window[23:0], b};
                if (pos < 17'd4)
                    pos = pos + 17'd1;
                if (pos >= 17'd4 && (hunt_window == START_I || hunt_window == START_P ||
                                     hunt_window == START_AUDIO)) begin
                    phase = PH_HEAD;
                    pos = 17'd0;
                end
            end
        endcase
    endtask

    task automatic compare_field(input string tag, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            faults++;
            $display("%0t %s expected %0h actual %0h", $time, tag, want, got);
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        t_stream_byte it;
        it.val = b;
        it.gap = gen_quiet ? 4'd0 : 4'($urandom_range(0, 15));
        it.hold = gen_hold;
        gen_hold = 1'b0;
        byte_q.push_back(it);
        gen_count++;
    endtask

    // stray bytes between frames never complete a start code
    task automatic push_noise(input logic [7:0] b);
        logic [7:0] v;
        v = b;
        if (gen_hist == 24'h00_0001 && (v == 8'hEA || v == 8'hEC || v == 8'hED))
            v = v + 8'h10;
        gen_hist = {gen_hist[15:0], v};
        push_byte(v);
    endtask

    task automatic push_frame(input logic [7:0] code, input logic [15:0][7:0] hdr,
                              input int unsigned ext_lo, input int unsigned ext_hi,
                              input logic [31:0] flen);
        int unsigned e;
        int unsigned k;
        logic [15:0] len;
        gen_quiet = (ext_hi > 1000) || ($urandom_range(0, 3) == 0);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(code);
        for (k = 0; k < 16; k++)
            push_byte(hdr[k]);
        for (e = 0; e < hdr[14]; e++) begin
            len = 16'($urandom_range(ext_hi, ext_lo));
            push_byte(8'($urandom_range(0, 255)));
            push_byte(8'($urandom_range(0, 255)));
            push_byte(len[7:0]);
            push_byte(len[15:8]);
            for (k = 0; k < len; k++)
                push_byte(8'($urandom_range(0, 255)));
        end
        for (k = 0; k < 4; k++)
            push_byte(flen[8 * k +: 8]);
        gen_hist = 24'hFF_FFFF;
        frames_made++;
    endtask

    function automatic logic [15:0][7:0] rand_header();
        logic [15:0][7:0] h;
        int unsigned k;
        for (k = 0; k < 16; k++)
            h[k] = 8'($urandom_range(0, 255));
        h[14] = 8'd0;
        return h;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_loaded = 1'b0;
            tx_busy = 1'b0;
            tx_wait = 0;
            drv_edge = 32'd0;
            hunt_window = 32'd0;
            phase = PH_HUNT;
            pos = 17'd0;
            ext_left = 8'd0;
            ext_sum = 24'd0;
            len_word = 32'd0;
            last_seq = 8'd0;
        end else begin
            drv_edge = drv_edge + 32'd1;
            if (i_valid && !o_stall)
                parse_byte(i_byte_value);
            tx_busy = i_valid && o_stall;
            if (!tx_busy && !tx_loaded && byte_q.size() != 0) begin
                tx_item = byte_q.pop_front();
                tx_wait = tx_item.gap;
                tx_loaded = 1'b1;
            end
            if (tx_loaded && !tx_busy) begin
                if (tx_wait != 0) begin
                    tx_wait--;
                end else if (!tx_item.hold || descs_done == descs_made) begin
                    tx_busy = 1'b1;
                    tx_loaded = 1'b0;
                end
            end
            i_valid <= tx_busy;
            if (tx_busy)
                i_byte_value <= tx_item.val;
        end
    end

    always @(posedge i_clk) begin
        t_due want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_quiet = 1'b0;
            rx_wait = 0;
            mon_edge = 32'd0;
        end else begin
            mon_edge = mon_edge + 32'd1;
            if (o_valid && !i_stall) begin
                // an item predicted on this very edge is not yet due
                if (desc_due.size() == 0 || desc_due[0].stamp >= mon_edge) begin
                    faults++;
                    $display("%0t unexpected descriptor kind %0d length %0h", $time,
                             o_frame_kind, o_frame_length);
                end else begin
                    want = desc_due.pop_front();
                    compare_field("frame_kind", 32'(want.d.frame_kind), 32'(o_frame_kind));
                    compare_field("codec", 32'(want.d.codec), 32'(o_codec));
                    compare_field("frame_rate", 32'(want.d.frame_rate), 32'(o_frame_rate));
                    compare_field("width", 32'(want.d.width), 32'(o_width));
                    compare_field("height", 32'(want.d.height), 32'(o_height));
                    compare_field("audio_stereo", 32'(want.d.audio_stereo),
                                  32'(o_audio_stereo));
                    compare_field("audio_rate_code", 32'(want.d.audio_rate_code),
                                  32'(o_audio_rate_code));
                    compare_field("audio_wide_samples", 32'(want.d.audio_wide_samples),
                                  32'(o_audio_wide_samples));
                    compare_field("time_of_day", 32'(want.d.time_of_day), 32'(o_time_of_day));
                    compare_field("date_code", 32'(want.d.date_code), 32'(o_date_code));
                    compare_field("frame_length", want.d.frame_length, o_frame_length);
                    compare_field("header_length", 32'(want.d.header_length),
                                  32'(o_header_length));
                    descs_done <= descs_done + 1;
                end
                if ($urandom_range(0, 7) == 0)
                    rx_quiet = !rx_quiet;
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 15);
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            i_stall <= (rx_wait != 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [15:0][7:0] h;
        logic [7:0]       code;
        logic [7:0]       hot [5];
        logic [31:0]      flen;
        int unsigned      k;
        int unsigned      n;
        int unsigned      ext_n;
        int unsigned      ext_hi;
        int unsigned      base_bytes;
        int unsigned      base_frames;

        hot = '{8'h00, 8'h01, 8'hEA, 8'hEC, 8'hED};

        // a start code pattern before four bytes have been seen is ignored
        push_noise(8'h01);
        push_noise(8'hED);
        push_noise(8'h37);

        h = '0;
        h[0] = 8'd1;
        push_frame(CODE_I, h, 0, 0, 32'd0);
        h = '1;
        h[14] = 8'd0;
        push_frame(CODE_I, h, 0, 0, 32'hFFFF_FFFF);
        h = rand_header();
        h[0] = 8'd2;
        h[3] = 8'd0;
        push_frame(CODE_P, h, 0, 0, $urandom);
        h = rand_header();
        h[0] = 8'd3;
        h[3] = 8'd1;
        push_frame(CODE_P, h, 0, 0, $urandom);
        h = rand_header();
        h[0] = 8'd4;
        h[3] = 8'd2;
        push_frame(CODE_P, h, 0, 0, $urandom);
        // sequence gaps upward and downward, the first one wrapping the length
        h = rand_header();
        h[0] = 8'd5;
        h[3] = 8'd5;
        push_frame(CODE_P, h, 0, 0, 32'd0);
        h = rand_header();
        h[0] = 8'd0;
        h[3] = 8'd3;
        push_frame(CODE_P, h, 0, 0, $urandom);
        h = rand_header();
        h[3] = 8'd3;
        push_frame(CODE_P, h, 0, 0, $urandom);
        h = rand_header();
        h[3] = 8'd99;
        h[4] = 8'hAB;
        h[5] = 8'd1;
        h[6] = 8'h80;
        h[7] = 8'd0;
        push_frame(CODE_AUDIO_BYTE(), h, 0, 0, $urandom);
        h = rand_header();
        h[5] = 8'd2;
        h[7] = 8'd1;
        push_frame(CODE_AUDIO_BYTE(), h, 0, 0, $urandom);
        h = rand_header();
        h[3] = 8'd4;
        push_frame(CODE_P, h, 0, 0, $urandom);

        // broken start codes, then extension chains
        push_noise(8'h00);
        push_noise(8'h00);
        push_noise(8'h01);
        push_noise(8'hEB);
        push_noise(8'h00);
        push_noise(8'h00);
        push_noise(8'h01);
        h = rand_header();
        h[14] = 8'd2;
        push_frame(CODE_I, h, 0, 5, $urandom);
        h = rand_header();
        h[14] = 8'd32;
        push_frame(CODE_AUDIO_BYTE(), h, 0, 0, $urandom);
        h = rand_header();
        h[3] = 8'd5;
        h[14] = 8'd1;
        push_frame(CODE_P, h, 300, 300, $urandom);

        base_bytes = gen_count;
        base_frames = frames_made;
        gen_seq = 8'd5;
        gen_hold = 1'b1;
        while (gen_count < base_bytes + RANDOM_BYTES ||
               frames_made < base_frames + RANDOM_FRAMES) begin
            if ($urandom_range(0, 15) == 0)
                gen_hold = 1'b1;
            n = $urandom_range(0, 6);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 3) == 0)
                    push_noise(hot[$urandom_range(0, 4)]);
                else
                    push_noise(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 5) == 0) begin
                push_noise(8'h00);
                push_noise(8'h00);
                push_noise(8'h01);
                push_noise(8'($urandom_range(0, 255)));
            end
            h = rand_header();
            if ($urandom_range(0, 1) == 0)
                h[0] = 8'($urandom_range(0, 6));
            case ($urandom_range(0, 5))
                0, 1:    gen_seq = gen_seq + 8'd1;
                2:       gen_seq = gen_seq;
                3:       gen_seq = 8'($urandom_range(0, 255));
                4:       gen_seq = 8'd0;
                default: gen_seq = 8'd255;
            endcase
            h[3] = gen_seq;
            k = $urandom_range(0, 19);
            ext_n = (k < 10) ? 0 : (k < 18) ? $urandom_range(1, 3) : $urandom_range(4, 12);
            h[14] = 8'(ext_n);
            ext_hi = ($urandom_range(0, 7) == 0) ? 300 : 8;
            case ($urandom_range(0, 7))
                0:       flen = 32'd0;
                1:       flen = 32'hFFFF_FFFF;
                default: flen = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0:       code = CODE_I;
                1, 2:    code = CODE_P;
                default: code = CODE_AUDIO_BYTE();
            endcase
            push_frame(code, h, 0, ext_hi, flen);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do
            @(negedge i_clk);
        while (byte_q.size() != 0 || tx_loaded || i_valid || descs_done != descs_made);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (faults == 0 && desc_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
